FILE: src/comic_pkg.sv
// Package for the center-of-mass image centering block: codes, state
// encoding, and the command and status words between controller and datapath.
// No dependencies.
package comic_pkg;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 6;
  localparam int SHIFT_W    = 7;
  localparam int QUOT_STEPS = 7;
  localparam int STEP_W     = 3;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_CENTRE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_READ, ST_CLEAR,
    ST_BOX, ST_BOX_END, ST_BOX_CHK,
    ST_SUM, ST_SUM_END,
    ST_DIVR_LOAD, ST_DIVR_RUN, ST_DIVR_STORE,
    ST_DIVC_LOAD, ST_DIVC_RUN, ST_DIVC_STORE,
    ST_SHIFT_CHK, ST_SHIFT, ST_SHIFT_END
  } state_e;

  typedef enum logic [1:0] {
    SCAN_BOX, SCAN_SUM, SCAN_SHIFT
  } scan_mode_e;

  typedef enum logic [1:0] {
    OUT_ZERO, OUT_READ, OUT_CENTRE
  } out_sel_e;

  typedef struct packed {
    logic       wr_input;
    logic       wr_zero;
    logic       zero_all;
    logic       cnt_clr;
    logic       cnt_step;
    logic       scan;
    scan_mode_e mode;
    logic       centre_clr;
    logic       div_load;
    logic       div_sel;
    logic       div_step;
    logic       div_store;
    logic       flip_bank;
    logic       load_out;
    out_sel_e   out_sel;
  } cmd_t;

  typedef struct packed {
    logic last_cell;
    logic scan_bank;
    logic found;
    logic div_last;
    logic zero_shift;
  } sts_t;

endpackage

FILE: src/comic_in_if.sv
// Input channel of the centering block: valid, ready and one command word.
// Depends on comic_pkg.
interface comic_in_if;
  logic                                valid;
  logic                                ready;
  comic_pkg::func_e                    func;
  logic [comic_pkg::COORD_W-1:0]       row;
  logic [comic_pkg::COORD_W-1:0]       col;
  logic [comic_pkg::PIX_W-1:0]         pixel_in;

  modport source (output valid, func, row, col, pixel_in, input ready);
  modport sink   (input valid, func, row, col, pixel_in, output ready);
endinterface

FILE: src/comic_out_if.sv
// Result channel of the centering block: valid, ready and one result word.
// Depends on comic_pkg.
interface comic_out_if;
  logic                                valid;
  logic                                ready;
  logic [comic_pkg::PIX_W-1:0]         pixel_out;
  logic signed [comic_pkg::SHIFT_W-1:0] shift_row;
  logic signed [comic_pkg::SHIFT_W-1:0] shift_col;
  logic                                grid_empty;

  modport source (output valid, pixel_out, shift_row, shift_col, grid_empty,
                  input ready);
  modport sink   (input valid, pixel_out, shift_row, shift_col, grid_empty,
                  output ready);
endinterface

FILE: src/comic_cfg_if.sv
// Configuration write channel of the centering block: the ink threshold.
// Depends on comic_pkg.
interface comic_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [comic_pkg::PIX_W-1:0]   ink_threshold;

  modport source (output valid, ink_threshold, input ready);
  modport sink   (input valid, ink_threshold, output ready);
endinterface

FILE: src/centre_of_mass_image_centering_top.sv
// Top level of the center-of-mass image centering block.
// Depends on comic_pkg, the three channel interfaces, comic_ctrl and comic_dp.
//
//   port    dir   word
//   in_i    in    func, row, col, pixel_in
//   out_o   out   pixel_out, shift_row, shift_col, grid_empty
//   cfg_i   in    ink_threshold
//
// A write loads its result word in the cycle it is taken; a read passes
// through ST_READ first, as the read port of the pixel memory is registered.
// A clear zeroes every cell of the current bank. A centre walks the grid up
// to three times through that port (box, moments, shift), with the two
// divisions between the moments and shift passes. After reset a clearing
// pass zeroes both banks; no word is taken meanwhile, though configuration
// writes are. One result word is held; a new word is taken only once it
// leaves, or in the cycle that it leaves.
module centre_of_mass_image_centering_top #(
  parameter int GRID_SIDE = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  comic_in_if.sink    in_i,
  comic_out_if.source out_o,
  comic_cfg_if.sink   cfg_i
);
  import comic_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Configuration is always accepted; the register sits in the datapath.
  assign cfg_i.ready = 1'b1;

  comic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_i.func),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  comic_dp #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .row_i        (in_i.row),
    .col_i        (in_i.col),
    .pixel_in_i   (in_i.pixel_in),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.ink_threshold),
    .pixel_out_o  (out_o.pixel_out),
    .shift_row_o  (out_o.shift_row),
    .shift_col_o  (out_o.shift_col),
    .grid_empty_o (out_o.grid_empty)
  );
endmodule

FILE: src/comic_dp.sv
// Datapath of the centering block: two-bank pixel memory, scan counters,
// bounding box and moment accumulators, shared divider, result register.
// Depends on comic_pkg.
module comic_dp #(
  parameter int GRID_SIDE = 28
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  comic_pkg::cmd_t                      cmd_i,
  output comic_pkg::sts_t                      sts_o,
  input  logic [comic_pkg::COORD_W-1:0]        row_i,
  input  logic [comic_pkg::COORD_W-1:0]        col_i,
  input  logic [comic_pkg::PIX_W-1:0]          pixel_in_i,
  input  logic                                 cfg_we_i,
  input  logic [comic_pkg::PIX_W-1:0]          cfg_data_i,
  output logic [comic_pkg::PIX_W-1:0]          pixel_out_o,
  output logic signed [comic_pkg::SHIFT_W-1:0] shift_row_o,
  output logic signed [comic_pkg::SHIFT_W-1:0] shift_col_o,
  output logic                                 grid_empty_o
);
  import comic_pkg::*;

  localparam int NN = GRID_SIDE * GRID_SIDE;
  localparam int AW = $clog2(2 * NN);
  localparam int WW = PIX_W + $clog2(NN + 1);
  localparam int RW = WW + COORD_W;
  localparam int DW = RW + 2;
  localparam logic [COORD_W-1:0] LAST = COORD_W'(GRID_SIDE - 1);
  localparam logic [DW-1:0] NM1 = DW'(GRID_SIDE - 1);
  localparam logic [COORD_W+1:0] SIDE = (COORD_W + 2)'(GRID_SIDE);
  localparam logic signed [SHIFT_W-1:0] HALF = SHIFT_W'(GRID_SIDE / 2);

  function automatic logic [AW-1:0] cell_addr(logic b, logic [COORD_W-1:0] r,
                                               logic [COORD_W-1:0] c);
    cell_addr = (b ? AW'(NN) : AW'(0)) + AW'(r) * AW'(GRID_SIDE) + AW'(c);
  endfunction

  logic [PIX_W-1:0] mem_q [2*NN];
  logic [PIX_W-1:0] rdata_q;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [PIX_W-1:0] wr_data;
  logic             wr_en;

  logic                bank_q, b_q;
  logic [COORD_W-1:0]  r_q, c_q;
  logic [PIX_W-1:0]    thr_q;
  logic                in_grid, in_grid_q;

  logic               p_vld_q, p_ok_q;
  scan_mode_e         p_mode_q;
  logic [COORD_W-1:0] p_r_q, p_c_q;

  logic               found_q;
  logic [COORD_W-1:0] min_r_q, max_r_q, min_c_q, max_c_q;
  logic [WW-1:0]      sw_q;
  logic [RW-1:0]      sr_q, sc_q;

  logic [DW-1:0]       rem_q, num, mag, trial, dv;
  logic [SHIFT_W-1:0]  quot_q;
  logic [STEP_W-1:0]   step_q;
  logic                neg_q;
  logic signed [SHIFT_W-1:0] sh_r_q, sh_c_q, sh_val;

  logic signed [COORD_W+1:0] src_r, src_c;
  logic                      src_ok;

  assign in_grid = (row_i <= LAST) && (col_i <= LAST);
  assign src_r  = $signed({2'b00, r_q}) - $signed({sh_r_q[SHIFT_W-1], sh_r_q});
  assign src_c  = $signed({2'b00, c_q}) - $signed({sh_c_q[SHIFT_W-1], sh_c_q});
  assign src_ok = !src_r[COORD_W+1] && (src_r < $signed(SIDE)) &&
                  !src_c[COORD_W+1] && (src_c < $signed(SIDE));

  // Memory ports.
  always_comb begin
    if (cmd_i.scan && cmd_i.mode == SCAN_SHIFT) begin
      rd_addr = cell_addr(bank_q, src_r[COORD_W-1:0], src_c[COORD_W-1:0]);
    end else if (cmd_i.scan) begin
      rd_addr = cell_addr(bank_q, r_q, c_q);
    end else begin
      rd_addr = cell_addr(bank_q, row_i, col_i);
    end
    wr_en   = 1'b0;
    wr_addr = cell_addr(bank_q, row_i, col_i);
    wr_data = pixel_in_i;
    if (p_vld_q && p_mode_q == SCAN_SHIFT) begin
      wr_en   = 1'b1;
      wr_addr = cell_addr(!bank_q, p_r_q, p_c_q);
      wr_data = p_ok_q ? rdata_q : '0;
    end else if (cmd_i.wr_zero) begin
      wr_en   = 1'b1;
      wr_addr = cell_addr(cmd_i.zero_all ? b_q : bank_q, r_q, c_q);
      wr_data = '0;
    end else if (cmd_i.wr_input) begin
      wr_en   = in_grid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q   <= mem_q[rd_addr];
    in_grid_q <= in_grid;
  end

  // Control registers: bank, counters, pipe valid, threshold, found flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q  <= 1'b0;
      b_q     <= 1'b0;
      r_q     <= '0;
      c_q     <= '0;
      p_vld_q <= 1'b0;
      thr_q   <= PIX_W'(2);
      found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      if (cmd_i.flip_bank) begin
        bank_q <= !bank_q;
      end
      if (cmd_i.cnt_clr) begin
        r_q <= '0;
        c_q <= '0;
        b_q <= 1'b0;
      end else if (cmd_i.cnt_step) begin
        if (c_q == LAST) begin
          c_q <= '0;
          if (r_q == LAST) begin
            r_q <= '0;
            b_q <= !b_q;
          end else begin
            r_q <= r_q + COORD_W'(1);
          end
        end else begin
          c_q <= c_q + COORD_W'(1);
        end
      end
      p_vld_q <= cmd_i.scan;
      if (cmd_i.centre_clr) begin
        found_q <= 1'b0;
      end else if (p_vld_q && p_mode_q == SCAN_BOX && rdata_q > thr_q) begin
        found_q <= 1'b1;
      end
    end
  end

  // Scan pipe, box and moment accumulation.
  always_ff @(posedge clk_i) begin
    p_mode_q <= cmd_i.mode;
    p_r_q    <= r_q;
    p_c_q    <= c_q;
    p_ok_q   <= src_ok;
    if (cmd_i.centre_clr) begin
      sw_q <= '0;
      sr_q <= '0;
      sc_q <= '0;
    end else if (p_vld_q && p_mode_q == SCAN_BOX && rdata_q > thr_q) begin
      if (!found_q || p_r_q < min_r_q) min_r_q <= p_r_q;
      if (!found_q || p_r_q > max_r_q) max_r_q <= p_r_q;
      if (!found_q || p_c_q < min_c_q) min_c_q <= p_c_q;
      if (!found_q || p_c_q > max_c_q) max_c_q <= p_c_q;
    end else if (p_vld_q && p_mode_q == SCAN_SUM &&
                 p_r_q >= min_r_q && p_r_q <= max_r_q &&
                 p_c_q >= min_c_q && p_c_q <= max_c_q) begin
      sw_q <= sw_q + WW'(rdata_q);
      sr_q <= sr_q + RW'(rdata_q) * RW'(p_r_q);
      sc_q <= sc_q + RW'(rdata_q) * RW'(p_c_q);
    end
  end

  // Divider: round half away from zero as floor((|num| + W) / (2W)),
  // one quotient bit per cycle.
  assign num    = NM1 * DW'(sw_q) - (DW'(cmd_i.div_sel ? sc_q : sr_q) << 1);
  assign mag    = num[DW-1] ? -num : num;
  assign dv     = DW'(sw_q) << 1;
  assign trial  = dv << step_q;
  assign sh_val = neg_q ? -$signed(quot_q) : $signed(quot_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.centre_clr) begin
      sh_r_q <= '0;
      sh_c_q <= '0;
    end else if (cmd_i.div_store) begin
      if (cmd_i.div_sel) sh_c_q <= sh_val;
      else               sh_r_q <= sh_val;
    end
    if (cmd_i.div_load) begin
      rem_q  <= mag + DW'(sw_q);
      neg_q  <= num[DW-1];
      quot_q <= '0;
      step_q <= STEP_W'(QUOT_STEPS - 1);
    end else if (cmd_i.div_step) begin
      if (rem_q >= trial) begin
        rem_q          <= rem_q - trial;
        quot_q[step_q] <= 1'b1;
      end
      step_q <= step_q - STEP_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pixel_out_o  <= '0;
      shift_row_o  <= '0;
      shift_col_o  <= '0;
      grid_empty_o <= 1'b0;
      case (cmd_i.out_sel)
        OUT_READ: begin
          pixel_out_o <= in_grid_q ? rdata_q : '0;
        end
        OUT_CENTRE: begin
          shift_row_o  <= sh_r_q;
          shift_col_o  <= sh_c_q;
          grid_empty_o <= !found_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign sts_o.last_cell  = (r_q == LAST) && (c_q == LAST);
  assign sts_o.scan_bank  = b_q;
  assign sts_o.found      = found_q;
  assign sts_o.div_last   = (step_q == '0);
  assign sts_o.zero_shift = (sh_r_q == '0) && (sh_c_q == '0);

  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_store && !cmd_i.div_sel |=> sh_r_q <= HALF && sh_r_q >= -HALF)
    else $error("row shift beyond half the grid");
  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q && !p_vld_q |-> min_r_q <= max_r_q && min_c_q <= max_c_q)
    else $error("bounding box inverted");
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q && p_mode_q == SCAN_SHIFT |-> !cmd_i.wr_zero && !cmd_i.wr_input)
    else $error("memory write port claimed twice");
endmodule

FILE: src/comic_ctrl.sv
// Controller of the centering block: sequences init sweep, clear, reads,
// writes and the centering passes. Depends on comic_pkg.
module comic_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  comic_pkg::func_e  in_func_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output comic_pkg::cmd_t   cmd_o,
  input  comic_pkg::sts_t   sts_i
);
  import comic_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free, accept;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign in_ready_o  = (state_q == ST_IDLE) && out_free;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mode = SCAN_BOX;
    cmd_o.out_sel = OUT_ZERO;
    case (state_q)
      ST_INIT: begin
        cmd_o.wr_zero  = 1'b1;
        cmd_o.zero_all = 1'b1;
        cmd_o.cnt_step = 1'b1;
        if (sts_i.last_cell && sts_i.scan_bank) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_func_i)
            FUNC_WRITE: begin
              cmd_o.wr_input = 1'b1;
              cmd_o.load_out = 1'b1;
            end
            FUNC_READ: state_d = ST_READ;
            FUNC_CENTRE: begin
              cmd_o.cnt_clr    = 1'b1;
              cmd_o.centre_clr = 1'b1;
              state_d          = ST_BOX;
            end
            default: begin
              cmd_o.cnt_clr = 1'b1;
              state_d       = ST_CLEAR;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd_o.load_out = 1'b1;
        cmd_o.out_sel  = OUT_READ;
        state_d        = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd_o.wr_zero  = 1'b1;
        cmd_o.cnt_step = 1'b1;
        if (sts_i.last_cell) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_BOX: begin
        cmd_o.scan     = 1'b1;
        cmd_o.cnt_step = 1'b1;
        if (sts_i.last_cell) state_d = ST_BOX_END;
      end
      ST_BOX_END: state_d = ST_BOX_CHK;
      ST_BOX_CHK: begin
        cmd_o.cnt_clr = 1'b1;
        if (sts_i.found) begin
          state_d = ST_SUM;
        end else begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_sel  = OUT_CENTRE;
          state_d        = ST_IDLE;
        end
      end
      ST_SUM: begin
        cmd_o.scan     = 1'b1;
        cmd_o.mode     = SCAN_SUM;
        cmd_o.cnt_step = 1'b1;
        if (sts_i.last_cell) state_d = ST_SUM_END;
      end
      ST_SUM_END: state_d = ST_DIVR_LOAD;
      ST_DIVR_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIVR_RUN;
      end
      ST_DIVR_RUN: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_DIVR_STORE;
      end
      ST_DIVR_STORE: begin
        cmd_o.div_store = 1'b1;
        state_d         = ST_DIVC_LOAD;
      end
      ST_DIVC_LOAD: begin
        cmd_o.div_sel  = 1'b1;
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIVC_RUN;
      end
      ST_DIVC_RUN: begin
        cmd_o.div_sel  = 1'b1;
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_DIVC_STORE;
      end
      ST_DIVC_STORE: begin
        cmd_o.div_sel   = 1'b1;
        cmd_o.div_store = 1'b1;
        state_d         = ST_SHIFT_CHK;
      end
      ST_SHIFT_CHK: begin
        cmd_o.cnt_clr = 1'b1;
        if (sts_i.zero_shift) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_sel  = OUT_CENTRE;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd_o.scan     = 1'b1;
        cmd_o.mode     = SCAN_SHIFT;
        cmd_o.cnt_step = 1'b1;
        if (sts_i.last_cell) state_d = ST_SHIFT_END;
      end
      ST_SHIFT_END: begin
        cmd_o.flip_bank = 1'b1;
        cmd_o.load_out  = 1'b1;
        cmd_o.out_sel   = OUT_CENTRE;
        state_d         = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = cmd_o.load_out ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> out_free)
    else $error("result overwritten before it was taken");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE)
    else $error("word taken while busy");
  a_one_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.scan, cmd_o.wr_zero, cmd_o.div_step, cmd_o.div_load}))
    else $error("two passes at once");
endmodule
